// File: design/spc_pkg.sv
// Shared constants and types for the sieve prime counter.
// No dependencies; imported by the sequencer and the top level.
package spc_pkg;

  localparam int LIMIT_W        = 10;
  localparam int COUNT_W        = 8;
  localparam int MAX_LIMIT_DEF  = 1024;
  localparam int SMALLEST_PRIME = 2;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
  } spc_res_t;

endpackage

// File: design/sieve_prime_counter_unit.sv
// Sieve prime counter: one limit in, one prime count out per beat.
// Each request runs fill, check, strike and count passes over the mark RAM for the
// effective limit; a limit below two goes straight to the result.
// Throughput: one request at a time; the next beat is taken once the result
// moves to the output register. Synchronous active-low reset clears control.
module sieve_prime_counter_unit import spc_pkg::*; #(
  parameter int MAX_LIMIT = MAX_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [LIMIT_W-1:0] in_limit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COUNT_W-1:0] out_prime_count
);

  localparam int AW = $clog2(MAX_LIMIT);

  spc_res_t           res;
  logic               res_take;
  logic               idle;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic               mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic               mem_rdata;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r;

  spc_seq #(.MAX_LIMIT(MAX_LIMIT)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && idle),
    .limit     (in_limit),
    .idle      (idle),
    .res       (res),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  spc_ram #(.WIDTH(1), .DEPTH(MAX_LIMIT)) u_marks (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready = idle;

  // Load the output register when it is empty or being drained
  assign res_take = res.valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_count_r <= res.count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_prime_count = out_count_r;

  // Sequencer goes busy after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready still high after accepting a beat");

  // A handed-over result shows at the output next cycle
  a_take_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> out_valid && out_prime_count == $past(res.count))
    else $error("handed-over result missing at output");

  // Output only becomes valid through a handover
  a_out_from_take: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(res_take))
    else $error("output valid without handover");

  // Mark store is never touched while idle
  a_idle_no_mem: assert property (@(posedge clk) disable iff (!rst_n)
    idle |-> !mem_we && !mem_re)
    else $error("mark store accessed while idle");

endmodule

// File: design/spc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module spc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/spc_seq.sv
// Sieve sequencer: fill, check, strike and count passes over the mark store.
// Depends on spc_pkg; drives the ports of one spc_ram instance.
module spc_seq import spc_pkg::*; #(
  parameter int MAX_LIMIT = MAX_LIMIT_DEF,
  localparam int AW = $clog2(MAX_LIMIT)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [LIMIT_W-1:0] limit,
  output logic               idle,
  output spc_res_t           res,
  input  logic               res_take,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic               mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  logic               mem_rdata
);

  // Working width: holds both the request limit and the top store address
  localparam int CW = (AW > LIMIT_W) ? AW : LIMIT_W;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_FILL   = 7'b0000010,
    ST_TEST   = 7'b0000100,
    ST_CHK    = 7'b0001000,
    ST_STRIKE = 7'b0010000,
    ST_COUNT  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } seq_state_t;

  seq_state_t         state_r, state_nxt;
  logic [CW-1:0]      lim_r, lim_nxt;
  logic [CW-1:0]      i_r, i_nxt;
  logic [CW:0]        sq_r, sq_nxt;
  logic [CW:0]        j_r, j_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               pend_r, pend_nxt;
  logic               drain_r, drain_nxt;

  logic [CW-1:0]      lim_ext;
  logic [CW-1:0]      lim_eff;
  logic [CW-1:0]      i_inc;
  logic [CW:0]        sq_inc;
  logic [CW:0]        j_inc;

  // Saturate the request limit to the top of the store
  assign lim_ext = CW'(limit);
  assign lim_eff = (lim_ext > CW'(MAX_LIMIT - 1)) ? CW'(MAX_LIMIT - 1) : lim_ext;

  // Next candidate and its square, kept by increment: (i+1)^2 = i^2 + 2i + 1
  assign i_inc  = i_r + CW'(1);
  assign sq_inc = sq_r + {i_r, 1'b0} + (CW+1)'(1);
  assign j_inc  = j_r + (CW+1)'(i_r);

  always_comb begin
    state_nxt = state_r;
    lim_nxt   = lim_r;
    i_nxt     = i_r;
    sq_nxt    = sq_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = 1'b0;
    drain_nxt = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = k_r[AW-1:0];
    mem_wdata = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = i_r[AW-1:0];

    // Accumulate marks returned by the count pass
    if (pend_r && mem_rdata) begin
      cnt_nxt = cnt_r + COUNT_W'(1);
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cnt_nxt = '0;
          lim_nxt = lim_eff;
          k_nxt   = '0;
          if (limit < LIMIT_W'(SMALLEST_PRIME)) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_FILL;
          end
        end
      end
      // Mark 0..limit, with 0 and 1 written clear
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[AW-1:0];
        mem_wdata = (k_r >= CW'(SMALLEST_PRIME));
        k_nxt     = k_r + CW'(1);
        if (k_r == lim_r) begin
          i_nxt     = CW'(SMALLEST_PRIME);
          sq_nxt    = (CW+1)'(SMALLEST_PRIME * SMALLEST_PRIME);
          state_nxt = ST_TEST;
        end
      end
      // Stop once i*i passes the limit, else fetch the mark of i
      ST_TEST: begin
        if (sq_r > {1'b0, lim_r}) begin
          k_nxt     = CW'(SMALLEST_PRIME);
          state_nxt = ST_COUNT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = i_r[AW-1:0];
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (mem_rdata) begin
          j_nxt     = sq_r;
          state_nxt = ST_STRIKE;
        end else begin
          i_nxt     = i_inc;
          sq_nxt    = sq_inc;
          state_nxt = ST_TEST;
        end
      end
      // Strike multiples of i from i*i up to the limit
      ST_STRIKE: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[AW-1:0];
        mem_wdata = 1'b0;
        j_nxt     = j_inc;
        if (j_inc > {1'b0, lim_r}) begin
          i_nxt     = i_inc;
          sq_nxt    = sq_inc;
          state_nxt = ST_TEST;
        end
      end
      // Stream reads over 2..limit, then a drain step collects the last read
      ST_COUNT: begin
        if (drain_r) begin
          state_nxt = ST_FINISH;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = k_r[AW-1:0];
          pend_nxt  = 1'b1;
          k_nxt     = k_r + CW'(1);
          drain_nxt = (k_r == lim_r);
        end
      end
      // Hold the result until the output register takes it
      ST_FINISH: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      drain_r <= drain_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    lim_r <= lim_nxt;
    i_r   <= i_nxt;
    sq_r  <= sq_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign res.valid = (state_r == ST_FINISH);
  assign res.count = cnt_r;

endmodule

// File: sim/sieve_prime_counter_unit_tb.sv
// Self-checking bench for sieve_prime_counter_unit: directed and random limits in, prime counts checked.
// Depends on spc_pkg and the unit's RTL; holds its own sieve to predict each count.
module sieve_prime_counter_unit_tb;
  import spc_pkg::*;

  localparam int SIEVE_SIZE  = MAX_LIMIT_DEF;
  localparam int RANDOM_REQS = 176;
  localparam int MAX_REPORTS = 10;

  // One request still waiting for its count
  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic [COUNT_W-1:0] count;
  } tally_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [LIMIT_W-1:0] in_limit = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [COUNT_W-1:0] out_prime_count;

  logic [LIMIT_W-1:0] limits_pending[$];
  tally_t             counts_due[$];
  int                 requests_taken = 0;
  int                 counts_checked = 0;
  int                 long_sweeps = 0;
  int                 fault_count = 0;
  logic               steady;

  sieve_prime_counter_unit #(
    .MAX_LIMIT(SIEVE_SIZE)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_limit       (in_limit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_prime_count(out_prime_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hold both sides busy without gaps over a stretch of the run
  assign steady = (requests_taken >= 80) && (requests_taken < 130);

  // Count primes in 2..limit with a private sieve
  function automatic logic [COUNT_W-1:0] primes_up_to(input logic [LIMIT_W-1:0] limit);
    bit struck[SIEVE_SIZE];
    int top;
    int n;
    n = 0;
    top = int'(limit);
    if (top < SMALLEST_PRIME) return '0;
    if (top >= SIEVE_SIZE) top = SIEVE_SIZE - 1;
    for (int k = 0; k < SIEVE_SIZE; k++) struck[k] = 1'b0;
    for (int p = SMALLEST_PRIME; p * p <= top; p++) begin
      if (!struck[p]) begin
        for (int m = p * p; m <= top; m += p) struck[m] = 1'b1;
      end
    end
    for (int k = SMALLEST_PRIME; k <= top; k++) begin
      if (!struck[k]) n++;
    end
    return COUNT_W'(n);
  endfunction

  // Driver: record each accepted beat, then offer the next limit or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_limit <= '0;
    end else begin
      if (in_valid && in_ready) begin
        counts_due.push_back('{limit: in_limit, count: primes_up_to(in_limit)});
        requests_taken <= requests_taken + 1;
        if (in_limit >= 512) long_sweeps <= long_sweeps + 1;
      end
      if (!in_valid || in_ready) begin
        if (limits_pending.size() > 0 && (steady || $urandom_range(99) >= 33)) begin
          in_valid <= 1'b1;
          in_limit <= limits_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each count beat with the oldest request, then stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (counts_due.size() == 0) begin
          fault_count <= fault_count + 1;
          if (fault_count < MAX_REPORTS)
            $display("unexpected count beat: got %0d", out_prime_count);
        end else begin
          tally_t want;
          want = counts_due.pop_front();
          counts_checked <= counts_checked + 1;
          if (out_prime_count !== want.count) begin
            fault_count <= fault_count + 1;
            if (fault_count < MAX_REPORTS)
              $display("count mismatch for limit %0d: expected %0d, got %0d",
                       want.limit, want.count, out_prime_count);
          end
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 33);
    end
  end

  // Stimulus: directed corners, then mostly short sweeps with a few long ones
  initial begin
    logic [LIMIT_W-1:0] corners[$];
    int pick;
    int total_reqs;
    // below two, tiny limits, around squares of primes, around powers of two,
    // alternating bit patterns and the top of the range
    corners = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd8, 10'd9,
                10'd24, 10'd25, 10'd48, 10'd49, 10'd120, 10'd121, 10'd255,
                10'd256, 10'd511, 10'd512, 10'd960, 10'd961, 10'd682,
                10'd341, 10'd1022, 10'd1023};
    foreach (corners[k]) limits_pending.push_back(corners[k]);
    for (int k = 0; k < RANDOM_REQS; k++) begin
      pick = $urandom_range(99);
      if (pick < 55)
        limits_pending.push_back(LIMIT_W'($urandom_range(63)));
      else if (pick < 80)
        limits_pending.push_back(LIMIT_W'($urandom_range(255, 64)));
      else if (pick < 92)
        limits_pending.push_back(LIMIT_W'($urandom_range(767, 256)));
      else
        limits_pending.push_back(LIMIT_W'($urandom_range(1023, 768)));
    end
    total_reqs = limits_pending.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: wait until every request has had its count checked
    while (counts_checked < total_reqs)
      @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d requests, %0d of them long sweeps with limit of 512 or more",
             requests_taken, long_sweeps);
    $display("checked %0d prime counts, %0d faults", counts_checked, fault_count);
    if (fault_count == 0)
      $display("sieve_prime_counter_unit_tb passed");
    else
      $display("sieve_prime_counter_unit_tb failed");
    $finish;
  end

  // Guard against a hung unit
  initial begin
    #50_000_000;
    $display("sieve_prime_counter_unit_tb failed");
    $finish;
  end

endmodule
